### sv/pc_pkg.sv
// ----------------------------------------------------------------------------
// pc_pkg
// Shared types and constants for the palette compaction block: command
// codes, transaction payload structs and table sizes.
// ----------------------------------------------------------------------------
package pc_pkg;

    // table geometry
    localparam int PALETTE_ENTRIES_DEFAULT = 256;
    localparam int TABLE_SLOTS             = 256;
    localparam int INDEX_W                 = 8;
    localparam int COLOUR_W                = 32;
    localparam int SIZE_W                  = 9;
    localparam int OP_W                    = 3;

    localparam logic [INDEX_W-1:0] UNUSED_CODE        = 8'hFF;
    localparam logic [SIZE_W-1:0]  PALETTE_SIZE_RESET = 9'd256;

    // command codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_MARK   = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd2;
    localparam logic [OP_W-1:0] OP_BUILD  = 3'd3;
    localparam logic [OP_W-1:0] OP_REMAP  = 3'd4;
    localparam logic [OP_W-1:0] OP_READ   = 3'd5;

    // input transaction
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [INDEX_W-1:0]  pixel_index;
        logic [COLOUR_W-1:0] colour_word;
    } pc_item_t;

    // result transaction
    typedef struct packed {
        logic [INDEX_W-1:0]  new_index;
        logic [COLOUR_W-1:0] new_colour;
        logic [SIZE_W-1:0]   new_palette_size;
    } pc_result_t;

endpackage

### sv/pc_ram.sv
// ----------------------------------------------------------------------------
// pc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/palette_compaction.sv
// ----------------------------------------------------------------------------
// palette_compaction
// Removes unused colours from an 8-bit indexed palette and remaps pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on item when start is high and busy is low. cfg_data
//   (palette size) is written with cfg_valid/cfg_ready while the block idles.
//   Clear, mark and load give no result. Remap and read
//   give one result on the cycle after acceptance, marked by done; a new
//   command may be accepted in that same cycle, so a pixel stream of marks
//   or remaps runs at one transaction per cycle.
//   Build walks all 256 translation slots, one per cycle, through the
//   translation, old palette and compact palette RAMs; each copy into the
//   compact palette is written in the cycle after its RAM read. busy stays
//   high through walk and drain; the size result shows with done in drain.
//   done is a one-cycle strobe: the receiver cannot stall, so a result is
//   taken in the cycle it shows.
//   Reset clears the used marks, the compact palette valid bits and the
//   count, and sets the palette size to 256; no clearing pass is needed.
// ----------------------------------------------------------------------------
module palette_compaction
    import pc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pc_item_t           item,
    output logic               done,
    output pc_result_t         result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SIZE_W-1:0]  cfg_data
);

    localparam int PAW = $clog2(PALETTE_ENTRIES);
    localparam int TAW = $clog2(TABLE_SLOTS);
    localparam logic [SIZE_W-1:0] PE_LIMIT = SIZE_W'(PALETTE_ENTRIES);
    localparam logic [TAW-1:0]    WALK_LAST = TAW'(TABLE_SLOTS - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // result kinds
    localparam logic [1:0] RSP_INDEX  = 2'd0;
    localparam logic [1:0] RSP_COLOUR = 2'd1;
    localparam logic [1:0] RSP_SIZE   = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [TAW-1:0]             walk_reg, walk_next;
    logic [SIZE_W-1:0]          count_reg, count_next;
    logic [SIZE_W-1:0]          palette_size_reg;
    logic [PALETTE_ENTRIES-1:0] mark_reg, mark_next;
    logic [PALETTE_ENTRIES-1:0] cvalid_reg, cvalid_next;
    logic                       cp_en_reg;
    logic [PAW-1:0]             cp_slot_reg;
    logic                       rsp_valid_reg, rsp_valid_next;
    logic [1:0]                 rsp_kind_reg, rsp_kind_next;
    logic                       rd_hit_reg;

    logic           accept;
    logic           idx_in_range;
    logic [PAW-1:0] idx_slot;
    logic           walk_in_range;
    logic [PAW-1:0] walk_slot;
    logic           walk_used;
    logic           walk_copy;

    logic                trans_we;
    logic [INDEX_W-1:0]  trans_wdata;
    logic [INDEX_W-1:0]  trans_rdata;
    logic                old_we;
    logic [COLOUR_W-1:0] old_rdata;
    logic [COLOUR_W-1:0] compact_rdata;

    assign accept        = start && !busy;
    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = !busy;
    assign idx_in_range  = ({1'b0, item.pixel_index} < PE_LIMIT);
    assign idx_slot      = item.pixel_index[PAW-1:0];
    assign walk_in_range = ({1'b0, walk_reg} < PE_LIMIT);
    assign walk_slot     = walk_reg[PAW-1:0];
    assign walk_used     = walk_in_range && mark_reg[walk_slot];
    assign walk_copy     = walk_used && ({1'b0, walk_reg} < palette_size_reg);

    // translation entry for the slot under the walk
    assign trans_we    = (state_reg == ST_WALK);
    assign trans_wdata = walk_used ? count_reg[INDEX_W-1:0] : UNUSED_CODE;
    assign old_we      = accept && (item.op == OP_LOAD) && idx_in_range;

    // translation table, written by the build walk, read by remap
    pc_ram #(
        .WIDTH (INDEX_W),
        .DEPTH (TABLE_SLOTS)
    ) u_trans_ram (
        .clk   (clk),
        .we    (trans_we),
        .waddr (walk_reg),
        .wdata (trans_wdata),
        .raddr (item.pixel_index),
        .rdata (trans_rdata)
    );

    // old palette, written by loads, read by the build walk
    pc_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_old_ram (
        .clk   (clk),
        .we    (old_we),
        .waddr (idx_slot),
        .wdata (item.colour_word),
        .raddr (walk_slot),
        .rdata (old_rdata)
    );

    // compact palette, written in the cycle after the walk reads each slot, read by read items
    pc_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_compact_ram (
        .clk   (clk),
        .we    (cp_en_reg),
        .waddr (cp_slot_reg),
        .wdata (old_rdata),
        .raddr (idx_slot),
        .rdata (compact_rdata)
    );

    // sequencer and mark bookkeeping
    always_comb
    begin
        state_next     = state_reg;
        walk_next      = walk_reg;
        count_next     = count_reg;
        mark_next      = mark_reg;
        cvalid_next    = cvalid_reg;
        rsp_valid_next = 1'b0;
        rsp_kind_next  = rsp_kind_reg;
        if (cp_en_reg)
        begin
            cvalid_next[cp_slot_reg] = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.op)
                        OP_CLEAR:
                        begin
                            mark_next = '0;
                        end
                        OP_MARK:
                        begin
                            if (idx_in_range)
                            begin
                                mark_next[idx_slot] = 1'b1;
                            end
                        end
                        OP_BUILD:
                        begin
                            state_next  = ST_WALK;
                            walk_next   = '0;
                            count_next  = '0;
                            cvalid_next = '0;
                        end
                        OP_REMAP:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_kind_next  = RSP_INDEX;
                        end
                        OP_READ:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_kind_next  = RSP_COLOUR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                walk_next = walk_reg + 1'b1;
                if (walk_used)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (walk_reg == WALK_LAST)
                begin
                    state_next     = ST_DRAIN;
                    rsp_valid_next = 1'b1;
                    rsp_kind_next  = RSP_SIZE;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            walk_reg         <= '0;
            count_reg        <= '0;
            palette_size_reg <= PALETTE_SIZE_RESET;
            mark_reg         <= '0;
            cvalid_reg       <= '0;
            cp_en_reg        <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            rsp_kind_reg     <= RSP_INDEX;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            count_reg     <= count_next;
            mark_reg      <= mark_next;
            cvalid_reg    <= cvalid_next;
            cp_en_reg     <= (state_reg == ST_WALK) && walk_copy;
            rsp_valid_reg <= rsp_valid_next;
            rsp_kind_reg  <= rsp_kind_next;
            if (cfg_valid && cfg_ready)
            begin
                palette_size_reg <= cfg_data;
            end
        end
    end

    // payload registers alongside the RAM reads
    always_ff @(posedge clk)
    begin
        cp_slot_reg <= count_reg[PAW-1:0];
        rd_hit_reg  <= idx_in_range && cvalid_reg[idx_slot];
    end

    // result transaction
    always_comb
    begin
        done   = rsp_valid_reg;
        result = '0;
        unique case (rsp_kind_reg)
            RSP_INDEX:  result.new_index        = trans_rdata;
            RSP_COLOUR: result.new_colour       = rd_hit_reg ? compact_rdata : '0;
            RSP_SIZE:   result.new_palette_size = count_reg;
            default:    result = '0;
        endcase
    end

`ifndef NO_ASSERTIONS
    // no result strobe while the walk is running
    a_no_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !done)
        else $error("result strobe during build walk");

    // used count never exceeds the palette entries
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= PE_LIMIT)
        else $error("used count above palette entries");

    // an accepted build starts the walk
    a_build_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.op == OP_BUILD) |=> (state_reg == ST_WALK && walk_reg == '0))
        else $error("build transaction did not start the walk");

    // compact writes land below the running count
    a_copy_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cp_en_reg |-> ({{(SIZE_W-PAW){1'b0}}, cp_slot_reg} < count_reg))
        else $error("compact palette write beyond used count");

    // the drain state carries the size result
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (done && rsp_kind_reg == RSP_SIZE))
        else $error("drain cycle without size result");
`endif

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for palette_compaction. A short table of directed
// commands (reset contents, index and colour extremes, undefined opcodes,
// unused-index translation) is followed by random image sessions: clear,
// mark and load, build, then remap and read traffic with noise mixed in.
// Sessions run under several palette sizes, the extremes among them. Every
// result is compared field by field against a table-level model of the
// block, kept in step at each accepted transaction.
// ----------------------------------------------------------------------------
module tb;
    import pc_pkg::*;

    localparam int WALK_LIMIT      = PALETTE_ENTRIES_DEFAULT;
    localparam int IDLE_LIMIT      = 5000;
    localparam int TAIL_CYCLES     = 300;
    localparam int CFG_SETTLE      = 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int PHASES          = 9;

    // opcodes the block ignores
    localparam logic [OP_W-1:0] OP_UNDEF6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF7 = 3'd7;

    typedef struct {
        pc_item_t   cmd;
        bit         typed;
        pc_result_t want;
    } stim_row_t;

    // dut ports
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    pc_item_t          item      = '0;
    logic              done;
    pc_result_t        result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data  = '0;

    // model of the palette tables
    bit                  model_used    [TABLE_SLOTS];
    logic [INDEX_W-1:0]  model_xlat    [TABLE_SLOTS];
    logic [COLOUR_W-1:0] model_old_pal [TABLE_SLOTS];
    logic [COLOUR_W-1:0] model_new_pal [TABLE_SLOTS];
    logic [SIZE_W-1:0]   model_count;
    logic [SIZE_W-1:0]   model_psize;

    // stimulus bookkeeping
    bit                pal_loaded [TABLE_SLOTS];
    bit                no_gaps        = 1'b0;
    stim_row_t         directed_rows[$];
    pc_result_t        pending_results[$];
    pc_result_t        want;
    logic [SIZE_W-1:0] psize_plan [PHASES];
    int                errors         = 0;
    int                idle_cycles    = 0;
    int                accepted_items = 0;

    palette_compaction DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // table model: updates state and returns 1 when a result is due
    function automatic bit predict_compaction(input pc_item_t it, output pc_result_t res);
        int count;
        int copy_lim;
        res = '0;
        case (it.op)
            OP_CLEAR:
            begin
                foreach (model_used[i]) model_used[i] = 1'b0;
                return 1'b0;
            end
            OP_MARK:
            begin
                if (it.pixel_index < WALK_LIMIT) model_used[it.pixel_index] = 1'b1;
                return 1'b0;
            end
            OP_LOAD:
            begin
                if (it.pixel_index < WALK_LIMIT) model_old_pal[it.pixel_index] = it.colour_word;
                return 1'b0;
            end
            OP_BUILD:
            begin
                count    = 0;
                copy_lim = (model_psize < WALK_LIMIT) ? int'(model_psize) : WALK_LIMIT;
                foreach (model_xlat[i]) model_xlat[i] = UNUSED_CODE;
                for (int i = 0; i < WALK_LIMIT; i++)
                begin
                    if (model_used[i])
                    begin
                        model_xlat[i] = count[INDEX_W-1:0];
                        count++;
                    end
                end
                foreach (model_new_pal[i]) model_new_pal[i] = '0;
                for (int i = 0; i < copy_lim; i++)
                begin
                    if (model_used[i]) model_new_pal[model_xlat[i]] = model_old_pal[i];
                end
                model_count          = count[SIZE_W-1:0];
                res.new_palette_size = model_count;
                return 1'b1;
            end
            OP_REMAP:
            begin
                res.new_index = model_xlat[it.pixel_index];
                return 1'b1;
            end
            OP_READ:
            begin
                res.new_colour = model_new_pal[it.pixel_index];
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // idle gap before a command: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // index inside the session's working window
    function automatic logic [INDEX_W-1:0] pick_index(input int base, input int span);
        int v;
        v = (base + $urandom_range(0, span)) % TABLE_SLOTS;
        return v[INDEX_W-1:0];
    endfunction

    function automatic void add_row(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                                    input logic [COLOUR_W-1:0] colour, input bit typed,
                                    input pc_result_t res);
        stim_row_t row;
        row.cmd   = '{op: op, pixel_index: idx, colour_word: colour};
        row.typed = typed;
        row.want  = res;
        directed_rows.push_back(row);
    endfunction

    // drive one command transaction and log what it should produce
    task automatic issue(input pc_item_t it, input bit typed, input pc_result_t typed_res);
        pc_result_t res;
        bit         has_res;
        int         gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        has_res = predict_compaction(it, res);
        if (has_res) pending_results.push_back(typed ? typed_res : res);
        if (it.op <= OP_READ) accepted_items++;
        if (it.op == OP_LOAD) pal_loaded[it.pixel_index] = 1'b1;
    endtask

    task automatic send(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                        input logic [COLOUR_W-1:0] colour);
        issue('{op: op, pixel_index: idx, colour_word: colour}, 1'b0, '0);
    endtask

    // load any marked entry below the palette size that was never written, then build
    task automatic build_palette();
        int lim;
        lim = (model_psize < WALK_LIMIT) ? int'(model_psize) : WALK_LIMIT;
        for (int i = 0; i < lim; i++)
        begin
            if (model_used[i] && !pal_loaded[i]) send(OP_LOAD, i[INDEX_W-1:0], $urandom);
        end
        send(OP_BUILD, INDEX_W'($urandom), $urandom);
    endtask

    // palette size write, only once the block has drained
    task automatic write_palette_size(input logic [SIZE_W-1:0] value);
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (CFG_SETTLE) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        model_psize = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one image: optional clear, marks and loads, build, then remap and read traffic
    task automatic run_session(input bit full);
        int                 n;
        int                 r;
        int                 base;
        int                 span;
        logic [INDEX_W-1:0] idx;
        no_gaps = ($urandom_range(0, 3) == 0);
        base    = $urandom_range(0, TABLE_SLOTS - 1);
        span    = ($urandom_range(0, 3) == 0) ? TABLE_SLOTS - 1 : $urandom_range(0, 31);
        if (full || $urandom_range(0, 4) != 0) send(OP_CLEAR, INDEX_W'($urandom), $urandom);
        if (full)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++) send(OP_MARK, i[INDEX_W-1:0], $urandom);
        end
        n = $urandom_range(1, 40);
        repeat (n)
        begin
            r   = $urandom_range(0, 99);
            idx = pick_index(base, span);
            if (r < 45)      send(OP_MARK, idx, $urandom);
            else if (r < 85) send(OP_LOAD, idx, $urandom);
            else if (r < 95) send(r[0] ? OP_UNDEF6 : OP_UNDEF7, INDEX_W'($urandom), $urandom);
            else             send(OP_READ, idx, $urandom);
        end
        build_palette();
        n = $urandom_range(10, 50);
        repeat (n)
        begin
            r   = $urandom_range(0, 99);
            idx = ($urandom_range(0, 9) < 7) ? pick_index(base, span) : INDEX_W'($urandom);
            if (r < 45)      send(OP_REMAP, idx, $urandom);
            else if (r < 62) send(OP_READ, idx, $urandom);
            else if (r < 80) send(OP_READ, INDEX_W'($urandom_range(0, model_count)), $urandom);
            else if (r < 85) send(OP_MARK, idx, $urandom);
            else if (r < 89) send(OP_LOAD, idx, $urandom);
            else if (r < 91) send(OP_CLEAR, INDEX_W'($urandom), $urandom);
            else if (r < 95) send(r[0] ? OP_UNDEF6 : OP_UNDEF7, INDEX_W'($urandom), $urandom);
            else             build_palette();
        end
    endtask

    // result checker and progress counter
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles = 0;
        else idle_cycles = idle_cycles + 1;
        if (done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none got %h", $time, result);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.new_index !== want.new_index)
                begin
                    $display("%0t: new_index expected %h got %h",
                             $time, want.new_index, result.new_index);
                    errors++;
                end
                if (result.new_colour !== want.new_colour)
                begin
                    $display("%0t: new_colour expected %h got %h",
                             $time, want.new_colour, result.new_colour);
                    errors++;
                end
                if (result.new_palette_size !== want.new_palette_size)
                begin
                    $display("%0t: new_palette_size expected %0d got %0d",
                             $time, want.new_palette_size, result.new_palette_size);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction at all
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        // model state after reset
        foreach (model_used[i])
        begin
            model_used[i]    = 1'b0;
            model_xlat[i]    = '0;
            model_old_pal[i] = '0;
            model_new_pal[i] = '0;
            pal_loaded[i]    = 1'b0;
        end
        model_count = '0;
        model_psize = PALETTE_SIZE_RESET;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset contents, empty build, undefined opcodes
        add_row(OP_READ,   8'd0,   32'h0,        1'b1, pc_result_t'{8'h00, 32'h0, 9'd0});
        add_row(OP_READ,   8'd255, 32'h0,        1'b1, pc_result_t'{8'h00, 32'h0, 9'd0});
        add_row(OP_BUILD,  8'd0,   32'h0,        1'b1, pc_result_t'{8'h00, 32'h0, 9'd0});
        add_row(OP_REMAP,  8'd0,   32'h0,        1'b1, pc_result_t'{8'hFF, 32'h0, 9'd0});
        add_row(OP_REMAP,  8'd255, 32'h0,        1'b1, pc_result_t'{8'hFF, 32'h0, 9'd0});
        add_row(OP_UNDEF6, 8'h55,  32'h0,        1'b0, '0);
        add_row(OP_UNDEF7, 8'hAA,  32'hFFFFFFFF, 1'b0, '0);
        // palette at both ends and the middle, then marks with a repeat
        add_row(OP_LOAD,   8'd0,   32'hFFFFFFFF, 1'b0, '0);
        add_row(OP_LOAD,   8'd255, 32'h00000000, 1'b0, '0);
        add_row(OP_LOAD,   8'd128, 32'hA5A5A5A5, 1'b0, '0);
        add_row(OP_LOAD,   8'd1,   32'h5A5A5A5A, 1'b0, '0);
        add_row(OP_MARK,   8'd0,   32'h0,        1'b0, '0);
        add_row(OP_MARK,   8'd255, 32'h0,        1'b0, '0);
        add_row(OP_MARK,   8'd128, 32'h0,        1'b0, '0);
        add_row(OP_MARK,   8'd1,   32'h0,        1'b0, '0);
        add_row(OP_MARK,   8'd1,   32'h0,        1'b0, '0);
        add_row(OP_BUILD,  8'd0,   32'h0,        1'b1, pc_result_t'{8'h00, 32'h0, 9'd4});
        // translation of used and unused indices
        add_row(OP_REMAP,  8'd0,   32'h0,        1'b1, pc_result_t'{8'h00, 32'h0, 9'd0});
        add_row(OP_REMAP,  8'd1,   32'h0,        1'b1, pc_result_t'{8'h01, 32'h0, 9'd0});
        add_row(OP_REMAP,  8'd128, 32'h0,        1'b1, pc_result_t'{8'h02, 32'h0, 9'd0});
        add_row(OP_REMAP,  8'd255, 32'h0,        1'b1, pc_result_t'{8'h03, 32'h0, 9'd0});
        add_row(OP_REMAP,  8'd2,   32'h0,        1'b1, pc_result_t'{8'hFF, 32'h0, 9'd0});
        // compacted palette, including a slot past the count
        add_row(OP_READ,   8'd0,   32'h0,        1'b1, pc_result_t'{8'h00, 32'hFFFFFFFF, 9'd0});
        add_row(OP_READ,   8'd2,   32'h0,        1'b0, '0);
        add_row(OP_READ,   8'd4,   32'h0,        1'b1, pc_result_t'{8'h00, 32'h0, 9'd0});
        foreach (directed_rows[r])
            issue(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);

        // palette sizes per phase; the first runs on the reset value
        psize_plan[0] = PALETTE_SIZE_RESET;
        psize_plan[1] = 9'd0;
        psize_plan[2] = 9'd1;
        psize_plan[3] = 9'd255;
        psize_plan[4] = 9'd511;
        psize_plan[5] = 9'd257;
        psize_plan[6] = SIZE_W'($urandom_range(2, 254));
        psize_plan[7] = 9'd256;
        psize_plan[8] = SIZE_W'($urandom_range(0, 511));

        for (int p = 0; p < PHASES; p++)
        begin
            int target;
            int sess;
            if (p > 0) write_palette_size(psize_plan[p]);
            target = accepted_items + ITEMS_PER_PHASE;
            sess   = 0;
            while (accepted_items < target)
            begin
                run_session(sess == 0 && (p == 0 || p == 4));
                sess++;
            end
        end

        // drain and let the block settle
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
sv/pc_pkg.sv
sv/pc_ram.sv
sv/palette_compaction.sv
dv/tb.sv
